/* src/pls_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_pkg
// Shared sizes, codes and bundles of the positional list store.
// ----------------------------------------------------------------------------
package pls_pkg;

   localparam int DEPTH            = 32;
   localparam int KEY_BITS         = 64;
   localparam int PAYLOAD_BITS     = 64;
   localparam int KEY_FIELD_BITS   = 64;
   localparam int POS_BITS         = 5;
   localparam int OP_BITS          = 3;
   localparam int STATUS_BITS      = 2;
   localparam int COUNT_FIELD_BITS = 6;
   localparam int ADDR_BITS        = $clog2(DEPTH);
   localparam int COUNT_BITS       = $clog2(DEPTH + 1);
   localparam int CMP_BITS         = (POS_BITS > COUNT_BITS) ? POS_BITS : COUNT_BITS;

   localparam int REQ_FIELD_BITS   = POS_BITS + 1 + KEY_FIELD_BITS + PAYLOAD_BITS;
   localparam int REQ_TDATA_BITS   = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int REQ_KEY_LSB      = POS_BITS + 1;
   localparam int REQ_PAYLOAD_LSB  = REQ_KEY_LSB + KEY_FIELD_BITS;

   localparam int RSP_FIELD_BITS   = POS_BITS + KEY_FIELD_BITS + PAYLOAD_BITS
                                     + COUNT_FIELD_BITS;
   localparam int RSP_TDATA_BITS   = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS     = RSP_TDATA_BITS - RSP_FIELD_BITS;

   typedef enum logic [OP_BITS-1:0] {
      OP_CLEAR  = 3'd0,
      OP_INSERT = 3'd1,
      OP_UPDATE = 3'd2,
      OP_DELETE = 3'd3,
      OP_READ   = 3'd4,
      OP_FIND   = 3'd5
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_BADPOS   = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef struct packed {
      op_type                  operation;
      logic [POS_BITS-1:0]     position;
      logic                    at_end;
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } request_type;

   typedef struct packed {
      logic                    wr_en;
      logic [ADDR_BITS-1:0]    wr_addr;
      logic [KEY_BITS-1:0]     wr_key;
      logic [PAYLOAD_BITS-1:0] wr_payload;
      logic                    rd_en;
      logic [ADDR_BITS-1:0]    rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [KEY_BITS-1:0]     key;
      logic [PAYLOAD_BITS-1:0] payload;
   } mem_rsp_type;

   typedef struct packed {
      status_type                  status;
      logic [POS_BITS-1:0]         found_position;
      logic [KEY_FIELD_BITS-1:0]   read_key;
      logic [PAYLOAD_BITS-1:0]     read_payload;
      logic [COUNT_FIELD_BITS-1:0] entry_count;
   } result_type;

endpackage

/* src/pls_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_store
// Entry memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pls_store (
   input  logic                 clock,
   input  pls_pkg::mem_req_type mem_req,
   output pls_pkg::mem_rsp_type mem_rsp
);

   logic [pls_pkg::KEY_BITS-1:0]     key_mem     [pls_pkg::DEPTH];
   logic [pls_pkg::PAYLOAD_BITS-1:0] payload_mem [pls_pkg::DEPTH];
   logic [pls_pkg::KEY_BITS-1:0]     rd_key_ff;
   logic [pls_pkg::PAYLOAD_BITS-1:0] rd_payload_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         key_mem[mem_req.wr_addr]     <= mem_req.wr_key;
         payload_mem[mem_req.wr_addr] <= mem_req.wr_payload;
      end
      if (mem_req.rd_en) begin
         rd_key_ff     <= key_mem[mem_req.rd_addr];
         rd_payload_ff <= payload_mem[mem_req.rd_addr];
      end
   end

   assign mem_rsp.key     = rd_key_ff;
   assign mem_rsp.payload = rd_payload_ff;

endmodule

/* src/pls_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pls_ctrl
// Sequencer: decodes one operation and walks the memory one entry per step
// for shifts and searches, with a single key compare used by find.
// ----------------------------------------------------------------------------
module pls_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pls_pkg::request_type req,
   output pls_pkg::mem_req_type mem_req,
   input  pls_pkg::mem_rsp_type mem_rsp,
   output logic                 res_valid,
   input  logic                 res_ready,
   output pls_pkg::result_type  res
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SHUP_RD,
      S_SHUP_WR,
      S_SHDN_RD,
      S_SHDN_WR,
      S_RD_CAP,
      S_FIND_RD,
      S_FIND_CMP,
      S_FINISH
   } state_type;

   state_type                            state_ff, state_in;
   pls_pkg::request_type                 req_ff, req_in;
   logic [pls_pkg::COUNT_BITS-1:0]       count_ff, count_in;
   logic [pls_pkg::COUNT_BITS-1:0]       idx_ff, idx_in;
   pls_pkg::status_type                  status_ff, status_in;
   logic [pls_pkg::POS_BITS-1:0]         found_ff, found_in;
   logic [pls_pkg::KEY_FIELD_BITS-1:0]   rkey_ff, rkey_in;
   logic [pls_pkg::PAYLOAD_BITS-1:0]     rpay_ff, rpay_in;

   logic [pls_pkg::CMP_BITS-1:0] cnt_ext;
   logic [pls_pkg::CMP_BITS-1:0] pos_ext;
   logic [pls_pkg::CMP_BITS-1:0] idx_ext;
   logic                         key_match;

   assign cnt_ext   = pls_pkg::CMP_BITS'(count_ff);
   assign pos_ext   = pls_pkg::CMP_BITS'(req_ff.position);
   assign idx_ext   = pls_pkg::CMP_BITS'(idx_ff);
   assign key_match = (mem_rsp.key == req_ff.key);

   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      status_in = status_ff;
      found_in  = found_ff;
      rkey_in   = rkey_ff;
      rpay_in   = rpay_ff;

      mem_req            = '0;
      mem_req.wr_key     = req_ff.key;
      mem_req.wr_payload = req_ff.payload;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            status_in = pls_pkg::ST_OK;
            found_in  = '0;
            rkey_in   = '0;
            rpay_in   = '0;
            state_in  = S_FINISH;
            case (req_ff.operation)
               pls_pkg::OP_CLEAR: begin
                  count_in = '0;
               end
               pls_pkg::OP_INSERT: begin
                  if (count_ff >= pls_pkg::COUNT_BITS'(pls_pkg::DEPTH)) begin
                     status_in = pls_pkg::ST_FULL;
                  end else if (req_ff.at_end) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pls_pkg::ADDR_BITS'(count_ff);
                     count_in        = count_ff + pls_pkg::COUNT_BITS'(1);
                  end else if (pos_ext > cnt_ext) begin
                     status_in = pls_pkg::ST_BADPOS;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_SHUP_RD;
                  end
               end
               pls_pkg::OP_UPDATE: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = pls_pkg::ST_BADPOS;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = pls_pkg::ADDR_BITS'(req_ff.position);
                  end
               end
               pls_pkg::OP_DELETE: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = pls_pkg::ST_BADPOS;
                  end else begin
                     idx_in   = pls_pkg::COUNT_BITS'(req_ff.position);
                     state_in = S_SHDN_RD;
                  end
               end
               pls_pkg::OP_READ: begin
                  if (pos_ext >= cnt_ext) begin
                     status_in = pls_pkg::ST_BADPOS;
                  end else begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = pls_pkg::ADDR_BITS'(req_ff.position);
                     state_in        = S_RD_CAP;
                  end
               end
               pls_pkg::OP_FIND: begin
                  status_in = pls_pkg::ST_NOTFOUND;
                  idx_in    = '0;
                  state_in  = S_FIND_RD;
               end
               default: begin
               end
            endcase
         end
         S_SHUP_RD: begin
            if (idx_ext == pos_ext) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pls_pkg::ADDR_BITS'(req_ff.position);
               count_in        = count_ff + pls_pkg::COUNT_BITS'(1);
               state_in        = S_FINISH;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pls_pkg::ADDR_BITS'(idx_ff - pls_pkg::COUNT_BITS'(1));
               state_in        = S_SHUP_WR;
            end
         end
         S_SHUP_WR: begin
            mem_req.wr_en      = 1'b1;
            mem_req.wr_addr    = pls_pkg::ADDR_BITS'(idx_ff);
            mem_req.wr_key     = mem_rsp.key;
            mem_req.wr_payload = mem_rsp.payload;
            idx_in             = idx_ff - pls_pkg::COUNT_BITS'(1);
            state_in           = S_SHUP_RD;
         end
         S_SHDN_RD: begin
            if (idx_ff + pls_pkg::COUNT_BITS'(1) == count_ff) begin
               count_in = count_ff - pls_pkg::COUNT_BITS'(1);
               state_in = S_FINISH;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pls_pkg::ADDR_BITS'(idx_ff + pls_pkg::COUNT_BITS'(1));
               state_in        = S_SHDN_WR;
            end
         end
         S_SHDN_WR: begin
            mem_req.wr_en      = 1'b1;
            mem_req.wr_addr    = pls_pkg::ADDR_BITS'(idx_ff);
            mem_req.wr_key     = mem_rsp.key;
            mem_req.wr_payload = mem_rsp.payload;
            idx_in             = idx_ff + pls_pkg::COUNT_BITS'(1);
            state_in           = S_SHDN_RD;
         end
         S_RD_CAP: begin
            rkey_in  = pls_pkg::KEY_FIELD_BITS'(mem_rsp.key);
            rpay_in  = mem_rsp.payload;
            state_in = S_FINISH;
         end
         S_FIND_RD: begin
            if (idx_ff == count_ff) begin
               state_in = S_FINISH;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = pls_pkg::ADDR_BITS'(idx_ff);
               state_in        = S_FIND_CMP;
            end
         end
         S_FIND_CMP: begin
            if (key_match) begin
               status_in = pls_pkg::ST_OK;
               found_in  = pls_pkg::POS_BITS'(idx_ff);
               state_in  = S_FINISH;
            end else begin
               idx_in   = idx_ff + pls_pkg::COUNT_BITS'(1);
               state_in = S_FIND_RD;
            end
         end
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      req_ff    <= req_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      found_ff  <= found_in;
      rkey_ff   <= rkey_in;
      rpay_ff   <= rpay_in;
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign res_valid          = (state_ff == S_FINISH);
   assign res.status         = status_ff;
   assign res.found_position = found_ff;
   assign res.read_key       = rkey_ff;
   assign res.read_payload   = rpay_ff;
   assign res.entry_count    = pls_pkg::COUNT_FIELD_BITS'(count_ff);

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= pls_pkg::COUNT_BITS'(pls_pkg::DEPTH))
      else $error("entry count above depth");

   a_shift_up_step: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SHUP_WR |=> idx_ff == $past(idx_ff) - pls_pkg::COUNT_BITS'(1))
      else $error("shift up index did not step down");

   a_find_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIND_CMP |-> idx_ff < count_ff)
      else $error("find compared past the last entry");

   a_finish_hold: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH && !res_ready |=> state_ff == S_FINISH && $stable(status_ff))
      else $error("result dropped while output slot busy");

endmodule

/* src/positional_list_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_store
// Ordered list of key and payload entries with clear, insert, update, delete,
// read and find, one result transfer per request transfer.
// ----------------------------------------------------------------------------
// Sequencing: clear, append, update and rejected operations go from decode
//   straight to the result; read adds a capture step; insert at a position and
//   delete move one entry per read and write step over the single memory port
//   pair; find reads and compares one entry per step until a match or the end.
//   One operation at a time: a new request is taken only when the sequencer is idle.
// Reset: clears the entry count and the sequencer; memory contents are kept.
// ----------------------------------------------------------------------------
module positional_list_store (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // position[4:0], at_end[5], entry_key[69:6], entry_payload[133:70]
   input  logic [pls_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // operation[2:0]
   input  logic [pls_pkg::OP_BITS-1:0]          req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // found_position[4:0], read_key[68:5], read_payload[132:69], entry_count[138:133]
   output logic [pls_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   // status[1:0]
   output logic [pls_pkg::STATUS_BITS-1:0]      rsp_tuser
);

   pls_pkg::request_type req;
   pls_pkg::mem_req_type mem_req;
   pls_pkg::mem_rsp_type mem_rsp;
   pls_pkg::result_type  res;
   logic                 res_valid;
   logic                 slot_free;

   logic                 rsp_valid_ff, rsp_valid_in;
   pls_pkg::result_type  rsp_ff, rsp_in;

   assign req.operation = pls_pkg::op_type'(req_tuser);
   assign req.position  = req_tdata[pls_pkg::POS_BITS-1:0];
   assign req.at_end    = req_tdata[pls_pkg::POS_BITS];
   assign req.key       = req_tdata[pls_pkg::REQ_KEY_LSB +: pls_pkg::KEY_BITS];
   assign req.payload   = req_tdata[pls_pkg::REQ_PAYLOAD_LSB +: pls_pkg::PAYLOAD_BITS];

   pls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_req   (mem_req),
      .mem_rsp   (mem_rsp),
      .res_valid (res_valid),
      .res_ready (slot_free),
      .res       (res)
   );

   pls_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .mem_rsp (mem_rsp)
   );

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {{pls_pkg::RSP_PAD_BITS{1'b0}}, rsp_ff.entry_count,
                        rsp_ff.read_payload, rsp_ff.read_key, rsp_ff.found_position};

endmodule
